// ===== hdl/sfe_pkg.sv =====
// ----------------------------------------------------------------------------
// sfe_pkg
// Types and constants shared by the telemetry frame encoder modules.
// ----------------------------------------------------------------------------
package sfe_pkg;

    // Line byte codes.
    localparam logic [7:0] STUFF_MARK = 8'h7D;
    localparam logic [7:0] FRAME_MARK = 8'h7E;
    localparam logic [7:0] STUFF_XOR  = 8'h20;
    localparam logic [7:0] CHECK_BASE = 8'hFF;

    // Raw bytes per frame, check byte included.
    localparam int unsigned FRAME_BYTES = 8;
    localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    // Frame queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // Input beat: one telemetry frame.
    typedef struct packed {
        logic        [7:0]  frame_header;
        logic        [15:0] sensor_id;
        logic signed [31:0] data_value;
    } in_beat_t;

    // Output beat: one line byte.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_beat_t;

    // Raw frame bytes in line order, byte 0 first.
    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    // Head of the frame queue as seen by the back.
    typedef struct packed {
        logic   valid;
        frame_t frame;
    } q_head_t;

    // Returns 1 when a byte must be escaped on the line.
    function automatic logic needs_stuff(input logic [7:0] b);
        return (b == STUFF_MARK) || (b == FRAME_MARK);
    endfunction

endpackage

// ===== hdl/sfe_front.sv =====
// ----------------------------------------------------------------------------
// sfe_front
// Accepts frames, splits them into raw line bytes and appends the check byte.
// ----------------------------------------------------------------------------
module sfe_front import sfe_pkg::*; (
    input  logic     s_valid,
    output logic     s_ready,
    input  in_beat_t s_data,
    input  logic     q_full,
    output logic     q_push,
    output frame_t   q_frame
);

    logic [6:0][7:0] raw;
    logic [7:0]      sum;
    logic [10:0]     total;
    logic [8:0]      fold;

    // The front takes a beat whenever the queue has room.
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Byte split: header, ID low first, value little-endian.
    always_comb begin
        raw[0] = s_data.frame_header;
        raw[1] = s_data.sensor_id[7:0];
        raw[2] = s_data.sensor_id[15:8];
        raw[3] = s_data.data_value[7:0];
        raw[4] = s_data.data_value[15:8];
        raw[5] = s_data.data_value[23:16];
        raw[6] = s_data.data_value[31:24];
    end

    // Eight-bit sum with end-around carry over the seven raw bytes. The bytes
    // are added in a balanced tree, then the carries above bit 7 are folded
    // back into the low byte twice; the second fold can no longer carry out.
    always_comb begin
        total = ({3'b000, raw[0]} + {3'b000, raw[1]})
              + ({3'b000, raw[2]} + {3'b000, raw[3]})
              + (({3'b000, raw[4]} + {3'b000, raw[5]}) + {3'b000, raw[6]});
        fold  = {1'b0, total[7:0]} + {6'b000000, total[10:8]};
        sum   = fold[7:0] + {7'b0, fold[8]};
    end

    // Assemble the frame with the check byte last.
    always_comb begin
        for (int i = 0; i < 7; i++) begin
            q_frame[i] = raw[i];
        end
        q_frame[FRAME_BYTES-1] = CHECK_BASE - sum;
    end

endmodule

// ===== hdl/sfe_queue.sv =====
// ----------------------------------------------------------------------------
// sfe_queue
// Short frame queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module sfe_queue import sfe_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  frame_t  push_frame,
    output logic    full,
    input  logic    pop,
    output q_head_t head
);

    frame_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.frame = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

    // The front must never push into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("frame pushed into a full queue");

    // The back must never pop an empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head.valid) else $error("frame popped from an empty queue");

endmodule

// ===== hdl/sfe_back.sv =====
// ----------------------------------------------------------------------------
// sfe_back
// Serializes queued frames into escaped line bytes, one beat per cycle while a frame is queued and m_ready allows.
// ----------------------------------------------------------------------------
module sfe_back import sfe_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  q_head_t   head,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             esc_reg, esc_next;
    logic             m_valid_reg, m_valid_next;
    out_beat_t        m_data_reg, m_data_next;
    logic [7:0]       cur_byte;
    logic             load;

    assign cur_byte = head.frame[idx_reg];
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // A new beat is loaded when a frame is queued and the output register is empty or being taken.
    assign load = head.valid && (!m_valid_reg || m_ready);

    // Byte sequencing with escape handling.
    always_comb begin
        idx_next     = idx_reg;
        esc_next     = esc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        pop          = 1'b0;
        if (load) begin
            m_valid_next = 1'b1;
            priority if (esc_reg) begin
                m_data_next.out_byte  = cur_byte ^ STUFF_XOR;
                m_data_next.last_byte = (idx_reg == LAST_IDX);
                esc_next              = 1'b0;
                idx_next              = idx_reg + 1'b1;
                pop                   = (idx_reg == LAST_IDX);
            end else if (needs_stuff(cur_byte)) begin
                m_data_next.out_byte  = STUFF_MARK;
                m_data_next.last_byte = 1'b0;
                esc_next              = 1'b1;
            end else begin
                m_data_next.out_byte  = cur_byte;
                m_data_next.last_byte = (idx_reg == LAST_IDX);
                idx_next              = idx_reg + 1'b1;
                pop                   = (idx_reg == LAST_IDX);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            esc_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            esc_reg     <= esc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // While an escape is pending, the escape mark sits in the output register.
    a_esc_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> (m_valid_reg && m_data_reg.out_byte == STUFF_MARK &&
                     !m_data_reg.last_byte))
        else $error("escape pending without escape mark on output");

    // After the last beat of a frame the sequencer is back at the first byte.
    a_last_rewinds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.last_byte) |-> (idx_reg == '0 && !esc_reg))
        else $error("last beat shown with sequencer mid-frame");

    // A frame leaves the queue only together with its last beat.
    a_pop_with_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (m_valid_reg && m_data_reg.last_byte))
        else $error("frame popped without its last beat");

endmodule

// ===== hdl/sport_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// sport_frame_encoder
// Telemetry frame encoder: check byte, byte stuffing and line serialization.
// ----------------------------------------------------------------------------
//  Channel  Dir  Ports                      Beat
//  s_       in   s_valid s_ready s_data     one frame (header, ID, value)
//  m_       out  m_valid m_ready m_data     one line byte with last flag
//
//  A frame produces 8 to 16 output beats, one per cycle while m_ready is high;
//  the byte sequencer in the back sets that figure, one line byte a cycle.
//  Frames are taken back to back into a two-entry queue, so a new frame is
//  accepted while earlier ones are still being sent.
//  Reset is synchronous and active low; it empties the queue and the output.
//  A stall on m_ready holds the output beat; s_ready drops when the queue fills.
// ----------------------------------------------------------------------------
module sport_frame_encoder import sfe_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    frame_t  q_frame;
    q_head_t q_head;

    // Front: accept frames and build raw bytes with the check byte.
    sfe_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_frame (q_frame)
    );

    // Queue between front and back.
    sfe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_frame (q_frame),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head)
    );

    // Back: escape and serialize onto the line.
    sfe_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (q_head),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
